// ===== src/tfn_pkg.sv =====
`default_nettype none
package tfn_pkg;
  // Fixed geometry of the stock configuration.
  localparam int unsigned COORD_W = 16;
  localparam int unsigned FRAC_W = 14;
  localparam int unsigned NORM_W = FRAC_W + 2;
  localparam int unsigned LEN_W = 2 * COORD_W + 2;

  // Control passed between pipeline cells.
  typedef struct packed {
    logic valid;
    logic degen;
  } cell_ctl_t;
endpackage
`default_nettype wire

// ===== src/tfn_if.sv =====
`default_nettype none
interface tfn_in_if #(parameter int unsigned CW = 16);
  logic valid;
  logic ready;
  logic signed [CW-1:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, output ready);
endinterface

interface tfn_out_if #(parameter int unsigned NW = 16, parameter int unsigned LW = 34);
  logic valid;
  logic ready;
  logic signed [NW-1:0] norm_x, norm_y, norm_z;
  logic [LW-1:0] cross_length;
  logic degenerate;
  modport source (output valid, norm_x, norm_y, norm_z, cross_length, degenerate,
                  input ready);
  modport sink (input valid, norm_x, norm_y, norm_z, cross_length, degenerate,
                output ready);
endinterface
`default_nettype wire

// ===== src/tfn_sqrt_cell.sv =====
`default_nettype none
// One restoring square-root step: decides one root bit per cell.
module tfn_sqrt_cell #(
  parameter int unsigned SW = 68,
  parameter int unsigned RW = 34,
  parameter int unsigned BIT = 0,
  parameter int unsigned PW = 50
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire tfn_pkg::cell_ctl_t ctl_in,
  input  wire logic [SW-1:0] rem_in,
  input  wire logic [RW-1:0] root_in,
  input  wire logic [PW-1:0] pay_in,
  output tfn_pkg::cell_ctl_t ctl_out,
  output logic [SW-1:0]      rem_out,
  output logic [RW-1:0]      root_out,
  output logic [PW-1:0]      pay_out
);
  tfn_pkg::cell_ctl_t ctl_r;
  logic [SW-1:0] rem_r, rem_nxt;
  logic [RW-1:0] root_r, root_nxt;
  logic [PW-1:0] pay_r;
  logic [SW+1:0] trial;

  // trial = (2*root + 2^bit) * 2^bit, compare with remainder
  always_comb begin
    trial = ({2'b0, {{(SW-RW){1'b0}}, root_in}} << (BIT + 1))
          + ({{(SW+1){1'b0}}, 1'b1} << (2 * BIT));
    rem_nxt = rem_in;
    root_nxt = root_in;
    if (trial <= {2'b0, rem_in}) begin
      rem_nxt = rem_in - trial[SW-1:0];
      root_nxt = root_in | (RW'(1) << BIT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      root_r <= root_nxt;
      pay_r <= pay_in;
    end
  end

  assign ctl_out = ctl_r;
  assign rem_out = rem_r;
  assign root_out = root_r;
  assign pay_out = pay_r;
endmodule
`default_nettype wire

// ===== src/tfn_div_cell.sv =====
`default_nettype none
// One restoring division step for three magnitudes sharing one divisor.
module tfn_div_cell #(
  parameter int unsigned LW = 34,
  parameter int unsigned NW = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire tfn_pkg::cell_ctl_t ctl_in,
  input  wire logic [LW-1:0] len_in,
  input  wire logic [2:0]    neg_in,
  input  wire logic [LW:0]   rem_in [3],
  input  wire logic [NW-1:0] quo_in [3],
  output tfn_pkg::cell_ctl_t ctl_out,
  output logic [LW-1:0]      len_out,
  output logic [2:0]         neg_out,
  output logic [LW:0]        rem_out [3],
  output logic [NW-1:0]      quo_out [3]
);
  tfn_pkg::cell_ctl_t ctl_r;
  logic [LW-1:0] len_r;
  logic [2:0] neg_r;
  logic [LW:0] rem_r [3], rem_nxt [3];
  logic [NW-1:0] quo_r [3], quo_nxt [3];
  logic [LW+1:0] sh;

  // shift remainder, subtract divisor when it fits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh = {rem_in[i], 1'b0};
      quo_nxt[i] = {quo_in[i][NW-2:0], 1'b0};
      rem_nxt[i] = sh[LW:0];
      if (sh >= {2'b0, len_in}) begin
        rem_nxt[i] = (LW+1)'(sh - {2'b0, len_in});
        quo_nxt[i][0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len_r <= len_in;
      neg_r <= neg_in;
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign ctl_out = ctl_r;
  assign len_out = len_r;
  assign neg_out = neg_r;
  assign rem_out = rem_r;
  assign quo_out = quo_r;
endmodule
`default_nettype wire

// ===== src/triangle_face_normal.sv =====
`default_nettype none
// Channel  Dir  Word
// in       in   three vertices a, b, c, signed COORD_BITS each
// out      out  norm_x/y/z (Q1.NORM_FRAC_BITS), cross_length, degenerate
//
// One face per cycle unless the output stalls.
// The chain has one cell per root bit and one per fraction bit.
// The whole chain advances when the output register is empty or taken.
// rst_n (synchronous) clears only valid and degen control bits; data needs no reset.
module triangle_face_normal #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned NORM_FRAC_BITS = 14
) (
  input  wire logic clk,
  input  wire logic rst_n,
  tfn_in_if.sink    in_ch,
  tfn_out_if.source out_ch
);
  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned DW = CW + 1;
  localparam int unsigned PRW = 2 * DW;
  localparam int unsigned NCW = PRW + 1;
  localparam int unsigned SW = 2 * NCW;
  localparam int unsigned LW = 2 * CW + 2;
  localparam int unsigned RW = NCW;
  localparam int unsigned NW = NORM_FRAC_BITS + 2;
  localparam int unsigned PW = 3 * NCW;
  localparam int unsigned NQ = NORM_FRAC_BITS;

  logic en;
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // stage 1: edges and products
  logic v1_r, v2_r, v3_r;
  logic signed [PRW-1:0] p_r [6];
  logic signed [DW-1:0] dx, dy, dz, ex, ey, ez;
  always_comb begin
    dx = DW'(in_ch.a_x) - DW'(in_ch.b_x);
    dy = DW'(in_ch.a_y) - DW'(in_ch.b_y);
    dz = DW'(in_ch.a_z) - DW'(in_ch.b_z);
    ex = DW'(in_ch.b_x) - DW'(in_ch.c_x);
    ey = DW'(in_ch.b_y) - DW'(in_ch.c_y);
    ez = DW'(in_ch.b_z) - DW'(in_ch.c_z);
  end

  // stage 2: cross product; stage 3: squares, whose sum feeds the root chain
  logic signed [NCW-1:0] n_r [3];
  logic signed [NCW-1:0] n3_r [3];
  logic [SW-1:0] sq_r [3];
  logic [SW-1:0] ssum;
  logic [NCW-1:0] mag [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = n_r[i][NCW-1] ? NCW'(-n_r[i]) : NCW'(n_r[i]);
    end
    ssum = sq_r[0] + sq_r[1] + sq_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= dy * ez;
      p_r[1] <= dz * ey;
      p_r[2] <= dz * ex;
      p_r[3] <= dx * ez;
      p_r[4] <= dx * ey;
      p_r[5] <= dy * ex;
      n_r[0] <= NCW'(p_r[0]) - NCW'(p_r[1]);
      n_r[1] <= NCW'(p_r[2]) - NCW'(p_r[3]);
      n_r[2] <= NCW'(p_r[4]) - NCW'(p_r[5]);
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= SW'(mag[i]) * SW'(mag[i]);
        n3_r[i] <= n_r[i];
      end
    end
  end

  // square-root chain, one cell per root bit
  tfn_pkg::cell_ctl_t s_ctl [RW+1];
  logic [SW-1:0] s_rem [RW+1];
  logic [RW-1:0] s_root [RW+1];
  logic [PW-1:0] s_pay [RW+1];
  assign s_ctl[0] = '{valid: v3_r, degen: (ssum == '0)};
  assign s_rem[0] = ssum;
  assign s_root[0] = '0;
  assign s_pay[0] = {n3_r[2], n3_r[1], n3_r[0]};

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    tfn_sqrt_cell #(.SW(SW), .RW(RW), .BIT(RW - 1 - k), .PW(PW)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .ctl_in(s_ctl[k]), .rem_in(s_rem[k]), .root_in(s_root[k]), .pay_in(s_pay[k]),
      .ctl_out(s_ctl[k+1]), .rem_out(s_rem[k+1]), .root_out(s_root[k+1]),
      .pay_out(s_pay[k+1])
    );
  end

  // division chain; |n| <= len so the integer quotient bit is a compare
  logic [LW-1:0] len0;
  logic signed [NCW-1:0] nf [3];
  tfn_pkg::cell_ctl_t d_ctl [NQ+1];
  logic [LW-1:0] d_len [NQ+1];
  logic [2:0] d_neg [NQ+1];
  logic [LW:0] d_rem [NQ+1][3];
  logic [NW-1:0] d_quo [NQ+1][3];
  logic [NCW-1:0] nm [3];
  always_comb begin
    len0 = LW'(s_root[RW]);
    for (int i = 0; i < 3; i++) begin
      nf[i] = s_pay[RW][i*NCW +: NCW];
      nm[i] = nf[i][NCW-1] ? NCW'(-nf[i]) : NCW'(nf[i]);
      d_neg[0][i] = nf[i][NCW-1];
      if ({1'b0, nm[i]} >= {{(NCW+1-LW){1'b0}}, len0} && !s_ctl[RW].degen) begin
        d_quo[0][i] = NW'(1);
        d_rem[0][i] = (LW+1)'(nm[i]) - {1'b0, len0};
      end else begin
        d_quo[0][i] = '0;
        d_rem[0][i] = (LW+1)'(nm[i]);
      end
    end
  end
  assign d_ctl[0] = s_ctl[RW];
  assign d_len[0] = len0;

  for (genvar k = 0; k < NQ; k++) begin : g_div
    tfn_div_cell #(.LW(LW), .NW(NW)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .ctl_in(d_ctl[k]), .len_in(d_len[k]), .neg_in(d_neg[k]),
      .rem_in(d_rem[k]), .quo_in(d_quo[k]),
      .ctl_out(d_ctl[k+1]), .len_out(d_len[k+1]), .neg_out(d_neg[k+1]),
      .rem_out(d_rem[k+1]), .quo_out(d_quo[k+1])
    );
  end

  // output register
  logic ov_r;
  logic signed [NW-1:0] nx_r, ny_r, nz_r;
  logic [LW-1:0] len_r;
  logic dg_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= d_ctl[NQ].valid;
    end
  end

  // zero divisor on a degenerate face: force the normal to zero
  always_ff @(posedge clk) begin
    if (en) begin
      if (d_ctl[NQ].degen) begin
        nx_r <= '0;
        ny_r <= '0;
        nz_r <= '0;
      end else begin
        nx_r <= d_neg[NQ][0] ? -d_quo[NQ][0] : d_quo[NQ][0];
        ny_r <= d_neg[NQ][1] ? -d_quo[NQ][1] : d_quo[NQ][1];
        nz_r <= d_neg[NQ][2] ? -d_quo[NQ][2] : d_quo[NQ][2];
      end
      len_r <= d_len[NQ];
      dg_r <= d_ctl[NQ].degen;
    end
  end

  assign out_ch.valid = ov_r;
  assign out_ch.norm_x = nx_r;
  assign out_ch.norm_y = ny_r;
  assign out_ch.norm_z = nz_r;
  assign out_ch.cross_length = len_r;
  assign out_ch.degenerate = dg_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("result lost under stall");
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.degenerate |-> out_ch.cross_length == '0 &&
      out_ch.norm_x == '0 && out_ch.norm_y == '0 && out_ch.norm_z == '0)
    else $error("degenerate face with nonzero result");
  a_nondegen_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.degenerate |-> out_ch.cross_length != '0)
    else $error("zero length on non-degenerate face");
endmodule
`default_nettype wire

// ===== tb/triangle_face_normal_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module triangle_face_normal_tb;
  localparam int LATENCY = 2 * tfn_pkg::COORD_W + tfn_pkg::FRAC_W + 7;
  localparam int N_RANDOM = 1000;
  localparam longint CYCLE_LIMIT = 400000;

  typedef logic signed [tfn_pkg::COORD_W-1:0] coord_t;
  typedef logic signed [tfn_pkg::NORM_W-1:0] norm_t;

  typedef struct packed {
    coord_t ax, ay, az, bx, by, bz, cx, cy, cz;
  } face_t;

  typedef struct packed {
    norm_t nx, ny, nz;
    logic [tfn_pkg::LEN_W-1:0] len;
    logic degen;
  } normal_t;

  logic clk;
  logic rst_n;

  tfn_in_if #(.CW(tfn_pkg::COORD_W)) in_ch ();
  tfn_out_if #(.NW(tfn_pkg::NORM_W), .LW(tfn_pkg::LEN_W)) out_ch ();

  triangle_face_normal #(
    .COORD_BITS(tfn_pkg::COORD_W),
    .NORM_FRAC_BITS(tfn_pkg::FRAC_W)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Expected normals, oldest first
  normal_t expected_normals[$];
  int errors;
  int checked;
  int degen_seen;
  longint cycles;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_off;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Truncating divide of n * 2^FRAC_W by len, sign restored after
  function automatic norm_t scale_to_unit(longint n, longint unsigned len);
    longint unsigned mag;
    longint unsigned q;
    mag = (n < 0) ? longint'(-n) : longint'(n);
    q = (mag << tfn_pkg::FRAC_W) / len;
    return (n < 0) ? norm_t'(-longint'(q)) : norm_t'(q);
  endfunction

  function automatic logic [63:0] isqrt(logic [127:0] s);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (128'(t) * 128'(t) <= s) r = t;
    end
    return r;
  endfunction

  function automatic normal_t face_normal(face_t f);
    longint dx, dy, dz, ex, ey, ez, nx, ny, nz;
    logic [127:0] sq;
    logic [63:0] len;
    normal_t r;
    dx = longint'(f.ax) - longint'(f.bx);
    dy = longint'(f.ay) - longint'(f.by);
    dz = longint'(f.az) - longint'(f.bz);
    ex = longint'(f.bx) - longint'(f.cx);
    ey = longint'(f.by) - longint'(f.cy);
    ez = longint'(f.bz) - longint'(f.cz);
    nx = dy * ez - dz * ey;
    ny = dz * ex - dx * ez;
    nz = dx * ey - dy * ex;
    // squares exceed 64 bits, so widen before multiplying
    sq = 128'(nx) * 128'(nx) + 128'(ny) * 128'(ny) + 128'(nz) * 128'(nz);
    r = '0;
    if (sq == 0) begin
      r.degen = 1'b1;
      return r;
    end
    len = isqrt(sq);
    r.nx = scale_to_unit(nx, len);
    r.ny = scale_to_unit(ny, len);
    r.nz = scale_to_unit(nz, len);
    r.len = len[tfn_pkg::LEN_W-1:0];
    return r;
  endfunction

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000);
      default: return coord_t'($signed($urandom_range(0, 40)) - 20);
    endcase
  endfunction

  function automatic face_t rand_face();
    face_t f;
    int mode;
    mode = $urandom_range(0, 2);
    f.ax = rand_coord(mode); f.ay = rand_coord(mode); f.az = rand_coord(mode);
    f.bx = rand_coord(mode); f.by = rand_coord(mode); f.bz = rand_coord(mode);
    f.cx = rand_coord(mode); f.cy = rand_coord(mode); f.cz = rand_coord(mode);
    // sometimes make the face collinear or repeat a vertex
    case ($urandom_range(0, 15))
      0: begin f.bx = f.ax; f.by = f.ay; f.bz = f.az; end
      1: begin f.cx = f.bx; f.cy = f.by; f.cz = f.bz; end
      2: begin f.cx = f.ax; f.cy = f.ay; f.cz = f.az; end
      default: ;
    endcase
    return f;
  endfunction

  // Send one face and log its prediction at acceptance
  task automatic send_face(face_t f, normal_t want, bit use_want);
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.a_x <= f.ax; in_ch.a_y <= f.ay; in_ch.a_z <= f.az;
    in_ch.b_x <= f.bx; in_ch.b_y <= f.by; in_ch.b_z <= f.bz;
    in_ch.c_x <= f.cx; in_ch.c_y <= f.cy; in_ch.c_z <= f.cz;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_normals.push_back(use_want ? want : face_normal(f));
  endtask

  // Receiver: random stalls plus an optional long hold-off
  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off > 0) begin
        out_ch.ready <= 1'b0;
        hold_off = hold_off - 1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
      @(posedge clk);
    end
  end

  // Result check at each accepted word
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      normal_t got;
      normal_t want;
      got = {out_ch.norm_x, out_ch.norm_y, out_ch.norm_z, out_ch.cross_length,
             out_ch.degenerate};
      if (expected_normals.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got);
        errors++;
      end else begin
        want = expected_normals.pop_front();
        checked++;
        if (got.degen) degen_seen++;
        if (got.nx !== want.nx || got.ny !== want.ny || got.nz !== want.nz ||
            got.len !== want.len || got.degen !== want.degen) begin
          $display("%0t: mismatch expected n=(%0d,%0d,%0d) len=%0d dg=%b", $time,
                   want.nx, want.ny, want.nz, want.len, want.degen);
          $display("%0t:          actual   n=(%0d,%0d,%0d) len=%0d dg=%b", $time,
                   got.nx, got.ny, got.nz, got.len, got.degen);
          errors++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout with %0d words outstanding", expected_normals.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Directed faces; typed-in results for the obvious ones
  face_t directed_faces[] = '{
    '{0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{5, 5, 5, 5, 5, 5, 5, 5, 5},
    '{0, 0, 0, 1, 0, 0, 2, 0, 0},
    '{1, 0, 0, 0, 0, 0, 0, 1, 0},
    '{0, 1, 0, 0, 0, 0, 0, 0, 1},
    '{0, 0, 1, 0, 0, 0, 1, 0, 0},
    '{0, 1, 0, 0, 0, 0, 1, 0, 0},
    '{32767, 32767, 32767, -32768, -32768, -32768, 32767, 32767, 32767},
    '{32767, -32768, 0, -32768, 32767, 0, 0, 0, 32767},
    '{-32768, -32768, -32768, 32767, -32768, -32768, 32767, 32767, -32768},
    '{32767, 0, 0, -32768, 0, 0, -32768, 32767, 32767},
    '{-1, -1, -1, 0, 0, 0, 1, 2, 3},
    '{3, 4, 0, 0, 0, 0, 0, 0, 1},
    '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, -32768, 32767},
    '{1, 1, 0, 0, 0, 0, 1, -1, 0},
    '{-21846, 21845, -1, 1, 2, 3, 21845, -21846, 16384}
  };
  // Known results: 0..1 degenerate, 2 collinear, 3..6 axis normals, 7 collinear
  normal_t directed_results[] = '{
    '{0, 0, 0, 0, 1},
    '{0, 0, 0, 0, 1},
    '{0, 0, 0, 0, 1},
    '{0, 0, -16384, 1, 0},
    '{-16384, 0, 0, 1, 0},
    '{0, -16384, 0, 1, 0},
    '{0, 0, 16384, 1, 0},
    '{0, 0, 0, 0, 1}
  };

  initial begin
    face_t f;
    errors = 0; checked = 0; degen_seen = 0; hold_off = 0;
    send_idle_pct = 0; recv_idle_pct = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    {in_ch.a_x, in_ch.a_y, in_ch.a_z, in_ch.b_x, in_ch.b_y, in_ch.b_z,
     in_ch.c_x, in_ch.c_y, in_ch.c_z} = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_faces[i])
      send_face(directed_faces[i],
                (i < directed_results.size()) ? directed_results[i] : normal_t'('0),
                i < directed_results.size());

    // Long receiver hold-off while the sender keeps offering words
    hold_off = 3 * LATENCY;
    for (int i = 0; i < 2 * LATENCY; i++) send_face(rand_face(), '0, 0);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 0) begin send_idle_pct = 24; recv_idle_pct = 74; end
      if (i == N_RANDOM / 3) begin send_idle_pct = 74; recv_idle_pct = 24; end
      if (i == 2 * N_RANDOM / 3) begin send_idle_pct = 0; recv_idle_pct = 0; end
      send_face(rand_face(), '0, 0);
    end
    in_ch.valid <= 1'b0;

    while (expected_normals.size() > 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);

    $display("Checked %0d faces (%0d degenerate) incl. extremes, collinear and",
             checked, degen_seen);
    $display("repeated vertices, under sender/receiver stalls and a long hold-off.");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
